### rtl/swmc_pkg.sv
`timescale 1ns / 1ps

package swmc_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 32;

    // Field widths of the external items
    localparam int CFG_BITS    = 7;
    localparam int SUM_BITS    = 38;
    localparam int IN_BITS     = 32;
    localparam int MEDIAN_BITS = 32;

    localparam int IDX_BITS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_BITS = $clog2(WINDOW_MAX + 1);
    localparam int CMP_BITS = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;

    localparam int OUT_FIELD_BITS = SUM_BITS + MEDIAN_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVICT,
        S_INSERT
    } t_state;

    // Operation broadcast to every sorted cell
    typedef struct packed {
        logic evict;
        logic insert;
    } t_cell_ctl;

endpackage

### rtl/swmc_ram.sv
`timescale 1ns / 1ps

module swmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/swmc_cell.sv
`timescale 1ns / 1ps

module swmc_cell (
    input  logic                                i_clk,
    input  swmc_pkg::t_cell_ctl                 i_ctl,
    input  logic [swmc_pkg::SAMPLE_BITS-1:0]    i_key,
    input  logic                                i_live,
    input  logic [swmc_pkg::SAMPLE_BITS-1:0]    i_left_val,
    input  logic                                i_left_flag,
    input  logic [swmc_pkg::SAMPLE_BITS-1:0]    i_right_val,
    output logic [swmc_pkg::SAMPLE_BITS-1:0]    o_val,
    output logic                                o_flag
);
    import swmc_pkg::*;

    logic [SAMPLE_BITS-1:0] r_val;
    logic [SAMPLE_BITS-1:0] n_val;
    logic                   w_flag;

    // Evict: flag marks cells at or past the deleted value; they pull from the right.
    // Insert: flag marks cells above the new value; the row moves right past it.
    always_comb begin
        if (i_ctl.insert) begin
            w_flag = !i_live || (r_val > i_key);
        end else begin
            w_flag = !i_live || (r_val >= i_key);
        end

        n_val = r_val;
        if (i_ctl.insert) begin
            if (i_left_flag) begin
                n_val = i_left_val;
            end else if (w_flag) begin
                n_val = i_key;
            end
        end else if (i_ctl.evict && w_flag) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.evict || i_ctl.insert) begin
            r_val <= n_val;
        end
    end

    assign o_val  = r_val;
    assign o_flag = w_flag;

endmodule

### rtl/sliding_window_median_cost.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tdata[31:0] = sample
// m_*       out        m_tvalid / m_tready  m_tdata[37:0] = window_cost,
//                                           m_tdata[69:38] = window_median
// i_cfg_*   in         i_cfg_we             i_cfg_wdata[6:0] = window_size
//
// A sample goes through accept, evict and insert once the window is full, and
// through accept and insert while it fills; the row of sorted cells does one shift
// per cycle and the registered history RAM gives the oldest sample the cycle after its read.
// Once inserted, the result loads the output register as soon as that is free,
// the same cycle in which the next sample can be accepted.
// Synchronous active-low reset sets window_size to 1 and empties the window.
// s_tready drops only while a sample is in work or a finished result finds
// the output register still full.
module sliding_window_median_cost (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [swmc_pkg::IN_TDATA_BITS-1:0]     s_tdata,     // [31:0] sample
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [swmc_pkg::OUT_TDATA_BITS-1:0]    m_tdata,     // [37:0] window_cost,
                                                                // [69:38] window_median
    input  logic                                   i_cfg_we,
    input  logic [swmc_pkg::CFG_BITS-1:0]          i_cfg_wdata
);
    import swmc_pkg::*;

    // Control state
    t_state                r_state, n_state;
    logic [CNT_BITS-1:0]   r_k, n_k;          // window size
    logic [CNT_BITS-1:0]   r_n, n_n;          // samples held
    logic [IDX_BITS-1:0]   r_ptr, n_ptr;      // oldest slot in the history
    logic [IDX_BITS-1:0]   r_slot, n_slot;    // slot of the transaction in work
    logic                  r_emit, n_emit;    // result ready to load
    logic                  r_m_tvalid, n_m_tvalid;

    // Payload
    logic [SAMPLE_BITS-1:0]     r_v, n_v;
    logic [SUM_BITS-1:0]        r_lower, n_lower;
    logic [SUM_BITS-1:0]        r_total, n_total;
    logic [OUT_TDATA_BITS-1:0]  r_m_tdata, n_m_tdata;

    // Cell row
    t_cell_ctl              w_ctl;
    logic [SAMPLE_BITS-1:0] w_key;
    logic [SAMPLE_BITS-1:0] w_val  [WINDOW_MAX];
    logic                   w_flag [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]  w_live;
    logic [WINDOW_MAX-1:0]  w_lo_mask;
    logic [CNT_BITS-1:0]    w_lim;

    // Half boundaries and selected values
    logic [CNT_BITS:0]      w_n_inc;
    logic [CNT_BITS-1:0]    w_lo_cnt;
    logic [SAMPLE_BITS-1:0] w_s_lm1;          // largest value of the lower half
    logic [SAMPLE_BITS-1:0] w_s_l;            // smallest value of the upper half
    logic                   w_hit_lo;

    // History RAM
    logic                   w_ram_we;
    logic [IDX_BITS-1:0]    w_ram_addr;
    logic [SAMPLE_BITS-1:0] w_old;
    logic [IDX_BITS-1:0]    w_slot_cur;
    logic [IDX_BITS-1:0]    w_slot_next;

    logic                   w_s_fire;
    logic                   w_load_out;
    logic [CMP_BITS-1:0]    w_cfg_ext;
    logic [SUM_BITS-1:0]    w_cost;
    logic [SUM_BITS-1:0]    w_odd_term;

    // Number of values in the lower half: ceil(n/2)
    assign w_n_inc  = {1'b0, r_n} + {{CNT_BITS{1'b0}}, 1'b1};
    assign w_lo_cnt = w_n_inc[CNT_BITS:1];

    // The pointer never passes k, but wrap it anyway before use
    assign w_slot_cur  = ({{(CNT_BITS-IDX_BITS){1'b0}}, r_ptr} >= r_k) ? '0 : r_ptr;
    assign w_slot_next = ({{(CNT_BITS-IDX_BITS){1'b0}}, r_slot} + CNT_BITS'(1) >= r_k)
                         ? '0 : r_slot + IDX_BITS'(1);

    assign w_load_out = r_emit && (!r_m_tvalid || m_tready);
    assign s_tready   = (r_state == S_IDLE) && (!r_emit || w_load_out);
    assign w_s_fire   = s_tvalid && s_tready;

    assign w_ram_we   = (r_state == S_INSERT);
    assign w_ram_addr = (r_state == S_INSERT) ? r_slot : w_slot_cur;

    swmc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (r_v),
        .o_rdata (w_old)
    );

    // Drive the cell row: evict compares against the oldest sample, insert against the new one
    always_comb begin
        w_ctl.evict  = (r_state == S_EVICT);
        w_ctl.insert = (r_state == S_INSERT);
        w_key        = (r_state == S_EVICT) ? w_old : r_v;
        // Evict checks the new lower half, floor(n/2); insert checks ceil((n+1)/2)
        if (r_state == S_EVICT) begin
            w_lim = r_n >> 1;
        end else begin
            w_lim = w_n_inc[CNT_BITS:0] == '0 ? '0 : CNT_BITS'((w_n_inc + 1'b1) >> 1);
        end
    end

    always_comb begin
        for (int i = 0; i < WINDOW_MAX; i++) begin
            w_live[i]    = (CNT_BITS'(i) < r_n);
            w_lo_mask[i] = (CNT_BITS'(i) < w_lim);
        end
    end

    genvar g;
    generate
        for (g = 0; g < WINDOW_MAX; g++) begin : g_cell
            logic [SAMPLE_BITS-1:0] w_left_val;
            logic                   w_left_flag;
            logic [SAMPLE_BITS-1:0] w_right_val;

            if (g == 0) begin : g_first
                assign w_left_val  = '0;
                assign w_left_flag = 1'b0;
            end else begin : g_mid
                assign w_left_val  = w_val[g-1];
                assign w_left_flag = w_flag[g-1];
            end

            if (g == WINDOW_MAX - 1) begin : g_last
                assign w_right_val = '0;
            end else begin : g_inner
                assign w_right_val = w_val[g+1];
            end

            swmc_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_key       (w_key),
                .i_live      (w_live[g]),
                .i_left_val  (w_left_val),
                .i_left_flag (w_left_flag),
                .i_right_val (w_right_val),
                .o_val       (w_val[g]),
                .o_flag      (w_flag[g])
            );
        end
    endgenerate

    // Pick the two values around the half boundary and check where the change lands
    always_comb begin
        w_s_lm1  = '0;
        w_s_l    = '0;
        w_hit_lo = 1'b0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            w_s_lm1  = w_s_lm1 | (w_val[i] & {SAMPLE_BITS{CNT_BITS'(i + 1) == w_lo_cnt}});
            w_s_l    = w_s_l   | (w_val[i] & {SAMPLE_BITS{CNT_BITS'(i) == w_lo_cnt}});
            w_hit_lo = w_hit_lo | (w_flag[i] && w_lo_mask[i]);
        end
    end

    // Cost = upper - lower = total - 2 * lower, plus the median for odd k
    assign w_odd_term = r_k[0] ? SUM_BITS'(w_s_lm1) : '0;
    assign w_cost     = r_total - {r_lower[SUM_BITS-2:0], 1'b0} + w_odd_term;

    assign w_cfg_ext  = CMP_BITS'(i_cfg_wdata);

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_n        = r_n;
        n_ptr      = r_ptr;
        n_slot     = r_slot;
        n_emit     = r_emit;
        n_v        = r_v;
        n_lower    = r_lower;
        n_total    = r_total;
        n_m_tvalid = r_m_tvalid;
        n_m_tdata  = r_m_tdata;

        // Output register: load a waiting result, drop valid once taken
        if (w_load_out) begin
            n_m_tvalid = 1'b1;
            n_m_tdata  = OUT_TDATA_BITS'({MEDIAN_BITS'(w_s_lm1), w_cost});
            n_emit     = 1'b0;
        end else if (m_tready) begin
            n_m_tvalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_s_fire) begin
                    n_v    = s_tdata[SAMPLE_BITS-1:0];
                    n_slot = w_slot_cur;
                    n_state = (r_n >= r_k) ? S_EVICT : S_INSERT;
                end
            end
            S_EVICT: begin
                // Drop the oldest sample; n goes to n-1
                n_total = r_total - SUM_BITS'(w_old);
                if (w_hit_lo) begin
                    n_lower = r_lower - SUM_BITS'(w_old)
                              + (r_n[0] ? '0 : SUM_BITS'(w_s_l));
                end else begin
                    n_lower = r_lower - (r_n[0] ? SUM_BITS'(w_s_lm1) : '0);
                end
                n_n     = r_n - CNT_BITS'(1);
                n_state = S_INSERT;
            end
            S_INSERT: begin
                // Place the new sample; n goes to n+1
                n_total = r_total + SUM_BITS'(r_v);
                if (w_hit_lo) begin
                    n_lower = r_lower + SUM_BITS'(r_v)
                              - (r_n[0] ? SUM_BITS'(w_s_lm1) : '0);
                end else begin
                    n_lower = r_lower + (r_n[0] ? '0 : SUM_BITS'(w_s_l));
                end
                n_n     = r_n + CNT_BITS'(1);
                n_ptr   = w_slot_next;
                n_emit  = (r_n + CNT_BITS'(1) >= r_k);
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A window size write empties the window; clamp to 1..WINDOW_MAX
        if (i_cfg_we) begin
            if (i_cfg_wdata == '0) begin
                n_k = CNT_BITS'(1);
            end else if (w_cfg_ext > CMP_BITS'(WINDOW_MAX)) begin
                n_k = CNT_BITS'(WINDOW_MAX);
            end else begin
                n_k = CNT_BITS'(w_cfg_ext);
            end
            n_n     = '0;
            n_ptr   = '0;
            n_lower = '0;
            n_total = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_k        <= CNT_BITS'(1);
            r_n        <= '0;
            r_ptr      <= '0;
            r_emit     <= 1'b0;
            r_m_tvalid <= 1'b0;
            r_lower    <= '0;
            r_total    <= '0;
        end else begin
            r_state    <= n_state;
            r_k        <= n_k;
            r_n        <= n_n;
            r_ptr      <= n_ptr;
            r_emit     <= n_emit;
            r_m_tvalid <= n_m_tvalid;
            r_lower    <= n_lower;
            r_total    <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v       <= n_v;
        r_slot    <= n_slot;
        r_m_tdata <= n_m_tdata;
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= r_k)
        else $error("fill count above window size");

    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_k != '0) && (r_k <= CNT_BITS'(WINDOW_MAX)))
        else $error("window size out of range");

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_tready)
        else $error("sample accepted while one is in work");

    a_evict_then_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVICT) |=> (r_state == S_INSERT))
        else $error("eviction not followed by insert");

    a_full_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INSERT && !i_cfg_we && (r_n + CNT_BITS'(1) == r_k)) |=> r_emit)
        else $error("full window produced no result");
`endif

endmodule
